### sv/sxu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sxu_pkg;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_SEL_FALL  = 3'd0,
    OP_RX_BYTE   = 3'd1,
    OP_SEL_RISE  = 3'd2,
    OP_HOST_TX   = 3'd3,
    OP_HOST_CMT  = 3'd4,
    OP_HOST_READ = 3'd5
  } sxu_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } sxu_state_t;

  typedef struct packed {
    logic clear;
    logic exec;
    logic load_out;
  } sxu_cmd_t;

  typedef struct packed {
    logic clear_last;
  } sxu_sts_t;

endpackage

`default_nettype wire

### sv/sxu_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sxu_in_if import sxu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output op, output data_byte, output position,
                  output length, input ready);
  modport sink   (input valid, input op, input data_byte, input position,
                  input length, output ready);
endinterface

`default_nettype wire

### sv/sxu_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sxu_out_if import sxu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] miso_byte;
  logic              ready_line;
  logic              attention_pulse;
  logic              accepted;
  logic [BYTE_W-1:0] rx_data;
  logic              rx_ready;
  logic              tx_pending;
  logic              transfer_active;

  modport source (output valid, output miso_byte, output ready_line,
                  output attention_pulse, output accepted, output rx_data,
                  output rx_ready, output tx_pending, output transfer_active,
                  input ready);
  modport sink   (input valid, input miso_byte, input ready_line,
                  input attention_pulse, input accepted, input rx_data,
                  input rx_ready, input tx_pending, input transfer_active,
                  output ready);
endinterface

`default_nettype wire

### sv/sxu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sxu_ctrl import sxu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire sxu_sts_t sts,
  output sxu_cmd_t      cmd
);

  sxu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/sxu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sxu_datapath import sxu_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sxu_cmd_t          cmd,
  output sxu_sts_t               sts,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [LEN_W-1:0]  length,
  output logic [BYTE_W-1:0]      miso_byte,
  output logic                   ready_line,
  output logic                   attention_pulse,
  output logic                   accepted,
  output logic [BYTE_W-1:0]      rx_data,
  output logic                   rx_ready,
  output logic                   tx_pending,
  output logic                   transfer_active
);

  localparam int          AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int          IW = $clog2(FRAME_BYTES + 1);
  localparam logic [31:0] FB = 32'(FRAME_BYTES);

  logic [BYTE_W-1:0] tx_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rx_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] tx_rd_r, rx_rd_r;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0] tx_len_r, tx_len_nxt;
  logic             rx_ready_r, rx_ready_nxt;
  logic             pending_r, pending_nxt;
  logic             active_r, active_nxt;
  logic             ready_lvl_r, ready_lvl_nxt;
  logic [AW-1:0]    clr_addr_r;

  logic miso_en_r, miso_en_nxt;
  logic attn_r, attn_nxt;
  logic acc_r, acc_nxt;
  logic rxd_en_r, rxd_en_nxt;

  logic              tx_we, tx_re, rx_we, rx_re;
  logic [AW-1:0]     tx_wa, tx_ra, rx_wa, rx_ra;
  logic [BYTE_W-1:0] tx_wd;

  sxu_op_t     op_e;
  logic [31:0] pos_w, len_w, idx_w, inc_w, txl_w;
  logic [IW-1:0] idx_inc;
  logic [AW-1:0] pos_a;

  always_comb begin
    op_e    = sxu_op_t'(op);
    pos_w   = 32'(position);
    len_w   = 32'(length);
    idx_w   = 32'(idx_r);
    idx_inc = idx_r + IW'(1);
    inc_w   = 32'(idx_inc);
    txl_w   = 32'(tx_len_r);
    pos_a   = pos_w[AW-1:0];

    idx_nxt       = idx_r;
    tx_len_nxt    = tx_len_r;
    rx_ready_nxt  = rx_ready_r;
    pending_nxt   = pending_r;
    active_nxt    = active_r;
    ready_lvl_nxt = ready_lvl_r;
    miso_en_nxt   = 1'b0;
    attn_nxt      = 1'b0;
    acc_nxt       = 1'b0;
    rxd_en_nxt    = 1'b0;
    tx_we = 1'b0;
    tx_wa = '0;
    tx_wd = '0;
    tx_re = 1'b0;
    tx_ra = '0;
    rx_we = 1'b0;
    rx_wa = '0;
    rx_re = 1'b0;
    rx_ra = '0;

    if (cmd.clear) begin
      tx_we = 1'b1;
      tx_wa = clr_addr_r;
    end

    if (cmd.exec) begin
      case (op_e)
        OP_SEL_FALL: begin
          idx_nxt       = '0;
          active_nxt    = 1'b1;
          ready_lvl_nxt = 1'b1;
          tx_re         = 1'b1;
          miso_en_nxt   = (txl_w != 32'd0);
        end
        OP_RX_BYTE: begin
          if (active_r && idx_w < FB) begin
            rx_we       = 1'b1;
            rx_wa       = idx_r[AW-1:0];
            idx_nxt     = idx_inc;
            tx_re       = 1'b1;
            tx_ra       = idx_inc[AW-1:0];
            miso_en_nxt = (inc_w < FB) && (inc_w < txl_w);
          end
        end
        OP_SEL_RISE: begin
          active_nxt    = 1'b0;
          rx_ready_nxt  = (idx_w == FB);
          idx_nxt       = '0;
          ready_lvl_nxt = 1'b0;
          if (pending_r) begin
            pending_nxt = 1'b0;
            tx_we       = 1'b1;
          end
        end
        OP_HOST_TX: begin
          if (pos_w < FB && !pending_r && !active_r) begin
            tx_we   = 1'b1;
            tx_wa   = pos_a;
            tx_wd   = data_byte;
            acc_nxt = 1'b1;
          end
        end
        OP_HOST_CMT: begin
          if (len_w <= FB && !pending_r && !active_r) begin
            tx_len_nxt    = length;
            pending_nxt   = 1'b1;
            ready_lvl_nxt = 1'b0;
            attn_nxt      = 1'b1;
            acc_nxt       = 1'b1;
          end
        end
        OP_HOST_READ: begin
          if (rx_ready_r && pos_w < FB) begin
            rx_re      = 1'b1;
            rx_ra      = pos_a;
            rxd_en_nxt = 1'b1;
            acc_nxt    = 1'b1;
            if (pos_w == FB - 32'd1) begin
              rx_ready_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.clear_last = (32'(clr_addr_r) == FB - 32'd1);

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wa] <= tx_wd;
    end
    if (tx_re) begin
      tx_rd_r <= tx_mem[tx_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wa] <= data_byte;
    end
    if (rx_re) begin
      rx_rd_r <= rx_mem[rx_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      tx_len_r    <= '0;
      rx_ready_r  <= 1'b0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      ready_lvl_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      idx_r       <= idx_nxt;
      tx_len_r    <= tx_len_nxt;
      rx_ready_r  <= rx_ready_nxt;
      pending_r   <= pending_nxt;
      active_r    <= active_nxt;
      ready_lvl_r <= ready_lvl_nxt;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      miso_en_r <= miso_en_nxt;
      attn_r    <= attn_nxt;
      acc_r     <= acc_nxt;
      rxd_en_r  <= rxd_en_nxt;
    end
    if (cmd.load_out) begin
      miso_byte       <= miso_en_r ? tx_rd_r : '0;
      ready_line      <= ready_lvl_r;
      attention_pulse <= attn_r;
      accepted        <= acc_r;
      rx_data         <= rxd_en_r ? rx_rd_r : '0;
      rx_ready        <= rx_ready_r;
      tx_pending      <= pending_r;
      transfer_active <= active_r;
    end
  end

endmodule

`default_nettype wire

### sv/spi_slave_frame_exchange_unit.sv
// SPI slave frame exchange unit.
// The in_ch channel carries one event per transaction: select falling, a received
// serial byte, select rising, a host transmit byte load, a host length commit or
// a host read of a received byte. The out_ch channel returns one result per
// event: the byte to shift out next, the ready line level, the attention pulse,
// the host acceptance flag, the read byte and the status flags after the event.
// Both channels use valid/ready; a transaction completes when both are high.
// For each event the buffer access and state update happen on the accepting
// edge; the result is registered later, from the response state, since each
// frame buffer has a single registered read port. No new event is accepted
// until that result is loaded. The result sits in an output register, so a
// new event is taken while the previous result is still waiting; if the
// receiver stalls, the unit holds the next result internally and stops
// accepting until the output register is free.
// After reset the transmit buffer is cleared by a pass over all FRAME_BYTES
// bytes, one byte per cycle, during which in_ch.ready stays low. The internal
// flags, the byte index and the committed length reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module spi_slave_frame_exchange_unit import sxu_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sxu_in_if.sink    in_ch,
  sxu_out_if.source out_ch
);

  sxu_cmd_t cmd;
  sxu_sts_t sts;

  sxu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sxu_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .op              (in_ch.op),
    .data_byte       (in_ch.data_byte),
    .position        (in_ch.position),
    .length          (in_ch.length),
    .miso_byte       (out_ch.miso_byte),
    .ready_line      (out_ch.ready_line),
    .attention_pulse (out_ch.attention_pulse),
    .accepted        (out_ch.accepted),
    .rx_data         (out_ch.rx_data),
    .rx_ready        (out_ch.rx_ready),
    .tx_pending      (out_ch.tx_pending),
    .transfer_active (out_ch.transfer_active)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second transaction accepted while one is in progress");

  a_active_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.transfer_active || out_ch.ready_line))
    else $error("transfer active with ready line idle");

  a_attention: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.attention_pulse |->
      out_ch.accepted && out_ch.tx_pending && !out_ch.ready_line)
    else $error("attention pulse without an accepted commit");

  a_rx_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.rx_data != '0) |-> out_ch.accepted)
    else $error("read data returned for a refused request");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb import sxu_pkg::*; ;

  localparam int FRAME = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_EVENTS = 1200;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] miso_byte;
    logic              ready_line;
    logic              attention_pulse;
    logic              accepted;
    logic [BYTE_W-1:0] rx_data;
    logic              rx_ready;
    logic              tx_pending;
    logic              transfer_active;
  } exchange_res_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    bit                typed;
    exchange_res_t     res;
  } script_row_t;

  logic clk;
  logic rst_n;

  sxu_in_if  in_ch ();
  sxu_out_if out_ch ();

  spi_slave_frame_exchange_unit #(
    .FRAME_BYTES(FRAME)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow of the exchange buffer state.
  logic [BYTE_W-1:0] tx_shadow [FRAME];
  logic [BYTE_W-1:0] rx_shadow [FRAME];
  logic [LEN_W-1:0]  shadow_index;
  logic [LEN_W-1:0]  shadow_length;
  logic              shadow_rx_ready;
  logic              shadow_tx_pending;
  logic              shadow_active;
  logic              shadow_ready_line;

  exchange_res_t exchange_results_due [$];
  script_row_t   script [$];

  int error_count = 0;
  int results_seen = 0;
  int events_sent = 0;
  int cycle_count = 0;
  int send_mode = 0;
  int recv_mode = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] tx_byte_at_index();
    if (shadow_index < FRAME && shadow_index < shadow_length) begin
      return tx_shadow[shadow_index[POS_W-1:0]];
    end
    return '0;
  endfunction

  function automatic exchange_res_t next_exchange_result(input logic [OP_W-1:0] op,
                                                         input logic [BYTE_W-1:0] data,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [LEN_W-1:0] len);
    exchange_res_t r;
    r = '0;
    case (op)
      OP_SEL_FALL: begin
        shadow_index = '0;
        shadow_active = 1'b1;
        r.miso_byte = tx_byte_at_index();
        shadow_ready_line = 1'b1;
      end
      OP_RX_BYTE: begin
        if (shadow_active && shadow_index < FRAME) begin
          rx_shadow[shadow_index[POS_W-1:0]] = data;
          shadow_index = shadow_index + 1'b1;
          r.miso_byte = tx_byte_at_index();
        end
      end
      OP_SEL_RISE: begin
        shadow_active = 1'b0;
        shadow_rx_ready = (shadow_index == FRAME);
        if (shadow_tx_pending) begin
          shadow_tx_pending = 1'b0;
          tx_shadow[0] = '0;
        end
        shadow_index = '0;
        shadow_ready_line = 1'b0;
      end
      OP_HOST_TX: begin
        if (!shadow_tx_pending && !shadow_active) begin
          tx_shadow[pos] = data;
          r.accepted = 1'b1;
        end
      end
      OP_HOST_CMT: begin
        if (len <= FRAME && !shadow_tx_pending && !shadow_active) begin
          shadow_length = len;
          shadow_tx_pending = 1'b1;
          shadow_ready_line = 1'b0;
          r.attention_pulse = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_HOST_READ: begin
        if (shadow_rx_ready) begin
          r.rx_data = rx_shadow[pos];
          r.accepted = 1'b1;
          if (pos == FRAME - 1) shadow_rx_ready = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.ready_line = shadow_ready_line;
    r.rx_ready = shadow_rx_ready;
    r.tx_pending = shadow_tx_pending;
    r.transfer_active = shadow_active;
    return r;
  endfunction

  // Offers one event and waits for its transaction; the prediction is queued on acceptance.
  task automatic drive_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.data_byte <= data;
    in_ch.position <= pos;
    in_ch.length <= len;
    do @(posedge clk); while (!in_ch.ready);
    exchange_results_due.push_back(next_exchange_result(op, data, pos, len));
    events_sent++;
    if (events_sent % 50 == 0) send_mode = $urandom_range(0, 2);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                         input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                         input bit typed, input logic [BYTE_W-1:0] miso,
                         input logic rline, input logic attn, input logic acc,
                         input logic [BYTE_W-1:0] rxd, input logic rxr,
                         input logic txp, input logic act);
    script_row_t row;
    row.op = op;
    row.data = data;
    row.pos = pos;
    row.len = len;
    row.typed = typed;
    row.res = '{miso, rline, attn, acc, rxd, rxr, txp, act};
    script.push_back(row);
  endtask

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [POS_W-1:0] any_pos();
    return POS_W'($urandom_range(0, FRAME - 1));
  endfunction

  function automatic logic [LEN_W-1:0] any_len();
    return LEN_W'($urandom_range(0, 127));
  endfunction

  task automatic stray_host_request();
    drive_event(OP_W'($urandom_range(OP_HOST_TX, OP_HOST_READ)), any_byte(), any_pos(),
                any_len());
  endtask

  // One frame exchange: host loads, an optional commit, transfer, then host reads.
  task automatic frame_exchange(input bit whole_frame);
    int count;
    int pick;
    logic [LEN_W-1:0] commit_len;
    bit reselect;
    if ($urandom_range(0, 5) == 0) begin
      for (int i = 0; i < FRAME; i++) begin
        drive_event(OP_HOST_TX, any_byte(), POS_W'(i), any_len());
      end
    end else begin
      count = $urandom_range(0, 6);
      for (int i = 0; i < count; i++) drive_event(OP_HOST_TX, any_byte(), any_pos(), any_len());
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) commit_len = LEN_W'(FRAME);
    else if (pick < 3) commit_len = '0;
    else if (pick < 4) commit_len = LEN_W'($urandom_range(FRAME + 1, 127));
    else commit_len = LEN_W'($urandom_range(1, FRAME - 1));
    if ($urandom_range(0, 3) != 0) drive_event(OP_HOST_CMT, any_byte(), any_pos(), commit_len);

    drive_event(OP_SEL_FALL, any_byte(), any_pos(), any_len());
    count = whole_frame ? FRAME : $urandom_range(0, FRAME - 1);
    if (whole_frame && $urandom_range(0, 4) == 0) count += $urandom_range(1, 3);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) stray_host_request();
      if (i == 3 && $urandom_range(0, 9) == 0) begin
        drive_event(OP_SEL_FALL, any_byte(), any_pos(), any_len());
        i = 0;
      end
      drive_event(OP_RX_BYTE, any_byte(), any_pos(), any_len());
    end
    drive_event(OP_SEL_RISE, any_byte(), any_pos(), any_len());

    reselect = ($urandom_range(0, 3) == 0);
    if (reselect) drive_event(OP_SEL_FALL, any_byte(), any_pos(), any_len());
    count = $urandom_range(0, 8);
    for (int i = 0; i < count; i++) begin
      if (reselect && $urandom_range(0, 2) == 0) begin
        drive_event(OP_RX_BYTE, any_byte(), any_pos(), any_len());
      end
      drive_event(OP_HOST_READ, any_byte(), any_pos(), any_len());
    end
    if ($urandom_range(0, 4) < 3) begin
      drive_event(OP_HOST_READ, any_byte(), POS_W'(FRAME - 1), any_len());
    end
    if (reselect) drive_event(OP_SEL_RISE, any_byte(), any_pos(), any_len());
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] expected,
                             input logic [BYTE_W-1:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    exchange_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (exchange_results_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual miso %0h",
                 $time, out_ch.miso_byte);
        error_count++;
      end else begin
        want = exchange_results_due.pop_front();
        check_field("miso_byte", want.miso_byte, out_ch.miso_byte);
        check_field("ready_line", BYTE_W'(want.ready_line), BYTE_W'(out_ch.ready_line));
        check_field("attention_pulse", BYTE_W'(want.attention_pulse),
                    BYTE_W'(out_ch.attention_pulse));
        check_field("accepted", BYTE_W'(want.accepted), BYTE_W'(out_ch.accepted));
        check_field("rx_data", want.rx_data, out_ch.rx_data);
        check_field("rx_ready", BYTE_W'(want.rx_ready), BYTE_W'(out_ch.rx_ready));
        check_field("tx_pending", BYTE_W'(want.tx_pending), BYTE_W'(out_ch.tx_pending));
        check_field("transfer_active", BYTE_W'(want.transfer_active),
                    BYTE_W'(out_ch.transfer_active));
      end
    end
  end

  // The receiver stalls once for a long stretch so that the unit fills and stops accepting.
  initial begin
    int gap;
    int taken;
    bit held_off;
    taken = 0;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = draw_wait(recv_mode);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 40 == 0) recv_mode = $urandom_range(0, 2);
    end
  end

  initial begin
    int pick;
    script_row_t row;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_SEL_FALL;
    in_ch.data_byte <= '0;
    in_ch.position <= '0;
    in_ch.length <= '0;
    for (int i = 0; i < FRAME; i++) begin
      tx_shadow[i] = '0;
      rx_shadow[i] = '0;
    end
    shadow_index = '0;
    shadow_length = '0;
    shadow_rx_ready = 1'b0;
    shadow_tx_pending = 1'b0;
    shadow_active = 1'b0;
    shadow_ready_line = 1'b0;

    //      op            data   pos  len     typed miso rl at ac rxd rr tp ta
    add_row(OP_HOST_READ, 8'h00, 0,   0,      1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SPARE_6,   8'hFF, 63,  127,    1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SPARE_7,   8'hFF, 63,  127,    1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_RX_BYTE,   8'hFF, 0,   0,      1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SEL_RISE,  8'h00, 0,   0,      1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_TX,   8'hFF, 0,   0,      1, 8'h00, 0, 0, 1, 8'h00, 0, 0, 0);
    add_row(OP_HOST_TX,   8'h00, 63,  0,      1, 8'h00, 0, 0, 1, 8'h00, 0, 0, 0);
    add_row(OP_HOST_TX,   8'hA5, 1,   0,      1, 8'h00, 0, 0, 1, 8'h00, 0, 0, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   127,    1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   65,     1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   2,      1, 8'h00, 0, 1, 1, 8'h00, 0, 1, 0);
    add_row(OP_HOST_TX,   8'h3C, 2,   0,      1, 8'h00, 0, 0, 0, 8'h00, 0, 1, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   64,     1, 8'h00, 0, 0, 0, 8'h00, 0, 1, 0);
    add_row(OP_SEL_FALL,  8'h00, 0,   0,      1, 8'hFF, 1, 0, 0, 8'h00, 0, 1, 1);
    add_row(OP_SEL_FALL,  8'h00, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_RX_BYTE,   8'h5A, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_RX_BYTE,   8'hC3, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_TX,   8'h77, 5,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_READ, 8'h00, 63,  0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SEL_RISE,  8'h00, 0,   0,      1, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   64,     0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_HOST_CMT,  8'h00, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SEL_FALL,  8'h00, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
    add_row(OP_SEL_RISE,  8'h00, 0,   0,      0, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      drive_event(row.op, row.data, row.pos, row.len);
      if (row.typed) exchange_results_due[exchange_results_due.size() - 1] = row.res;
    end

    while (events_sent < RANDOM_EVENTS + script.size()) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        frame_exchange(1'b1);
      end else if (pick < 15) begin
        frame_exchange(1'b0);
      end else begin
        for (int i = 0; i < 10; i++) begin
          drive_event(OP_W'($urandom_range(0, 7)), any_byte(), any_pos(), any_len());
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (exchange_results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/sxu_pkg.sv
sv/sxu_in_if.sv
sv/sxu_out_if.sv
sv/sxu_ctrl.sv
sv/sxu_datapath.sv
sv/spi_slave_frame_exchange_unit.sv
bench/tb.sv
